[rtl/s256_pkg.sv]
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

  localparam int WordW      = 32;
  localparam int BlockDepth = 16;
  localparam int HashDepth  = 8;
  localparam int LenW       = 61;

  localparam logic [WordW-1:0] PadMarker = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT_WAIT
  } s256_state_t;

  // Control from the sequencer to the schedule window and the round unit.
  typedef struct packed {
    logic       sched_load;
    logic       sched_step;
    logic       vars_load;
    logic       vars_round;
    logic       vars_shift;
    logic [5:0] round;
  } s256_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

[rtl/s256_ram.sv]
// ----------------------------------------------------------------------------
// s256_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module s256_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/s256_sched.sv]
// ----------------------------------------------------------------------------
// s256_sched
// Sixteen-word message schedule window: filled from the block memory, then
// advanced one expanded word per round.
// ----------------------------------------------------------------------------
module s256_sched import s256_pkg::*; (
  input  logic        clk,
  input  s256_ctl_t   ctl,
  input  logic [31:0] load_word,
  output logic [31:0] w_cur
);

  logic [31:0] win [BlockDepth];
  logic [31:0] w_new;

  assign w_new = win[0] + small_s0(win[1]) + win[9] + small_s1(win[14]);
  assign w_cur = win[0];

  always_ff @(posedge clk) begin
    if (ctl.sched_load || ctl.sched_step) begin
      for (int i = 0; i < BlockDepth - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlockDepth-1] <= ctl.sched_load ? load_word : w_new;
    end
  end

endmodule

[rtl/s256_round.sv]
// ----------------------------------------------------------------------------
// s256_round
// Working variables a..h and the SHA-256 round function, one round a cycle.
// ----------------------------------------------------------------------------
module s256_round import s256_pkg::*; (
  input  logic        clk,
  input  s256_ctl_t   ctl,
  input  logic [31:0] load_word,
  input  logic [31:0] w_cur,
  output logic [31:0] var_a
);

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] t1, t2;

  assign t1 = h + big_s1(e) + ((e & f) ^ (~e & g)) + round_k(ctl.round) + w_cur;
  assign t2 = big_s0(a) + ((a & b) ^ (a & c) ^ (b & c));
  assign var_a = a;

  always_ff @(posedge clk) begin
    if (ctl.vars_round) begin
      h <= g;
      g <= f;
      f <= e;
      e <= d + t1;
      d <= c;
      c <= b;
      b <= a;
      a <= t1 + t2;
    end else if (ctl.vars_load || ctl.vars_shift) begin
      // shift toward a: loading enters at h, folding drains from a
      a <= b;
      b <= c;
      c <= d;
      d <= e;
      e <= f;
      f <= g;
      g <= h;
      h <= load_word;
    end
  end

endmodule

[rtl/sha256_stream_hasher_core.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a stream of big-endian 32-bit words. Each word brings a count
// of valid leading bytes; a word marked last, or one with fewer than four
// bytes, closes the message, which is then padded (0x80, zeros, 64-bit bit
// length) and hashed. The eight digest words leave one transfer each, H0
// first, with digest_end on the eighth, and the hash restarts from the
// initial values. Words collect in a 16-entry block memory and the hash
// words live in an 8-entry memory. After reset a pass writes the initial
// hash values before the first word is taken. The sixteenth word of a
// block starts a compression, which reads the block and hash memories,
// runs the 64 rounds at one round a cycle and adds the result back into
// the hash memory; no word is taken while it runs. Closing a message
// writes the remaining pad words at one a cycle, runs one or two
// compressions, and sends each digest word through a read, a capture and a
// wait state, the wait lasting until its transfer.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core import s256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // message words
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  // digest words
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_end
);

  s256_state_t state, state_next;

  logic [6:0]      cnt;
  logic [3:0]      wib;
  logic [LenW-1:0] msg_bytes;
  logic            pad_active;
  logic            pad_mark;
  logic            len_phase;
  logic [2:0]      oidx;

  logic        in_xfer;
  logic        out_xfer;
  logic        in_full;
  logic        in_ending;
  logic [2:0]  in_count;
  logic [31:0] in_keep;
  logic [31:0] in_mark;
  logic [31:0] in_word;
  logic [31:0] pad_word;
  logic [31:0] len_hi;
  logic [31:0] len_lo;
  logic        msg_done;

  logic        blk_we;
  logic [31:0] blk_wdata;
  logic [31:0] blk_rdata;
  logic        hsh_we;
  logic [2:0]  hsh_waddr;
  logic [31:0] hsh_wdata;
  logic [2:0]  hsh_raddr;
  logic [31:0] hsh_rdata;

  s256_ctl_t   ctl;
  logic [31:0] w_cur;
  logic [31:0] var_a;

  assign in_xfer  = data_valid && data_ready;
  assign out_xfer = digest_valid && digest_ready;
  assign msg_done = out_xfer && (oidx == 3'd7);

  // Input word shaping: clamp the count, zero the unused bytes and drop the
  // pad marker right after the last valid byte of a short word.
  assign in_full   = byte_count[2];
  assign in_count  = in_full ? 3'd4 : byte_count;
  assign in_ending = last_word || !in_full;

  always_comb begin
    case (byte_count[1:0])
      2'd0:    begin in_keep = 32'h0000_0000; in_mark = 32'h8000_0000; end
      2'd1:    begin in_keep = 32'hff00_0000; in_mark = 32'h0080_0000; end
      2'd2:    begin in_keep = 32'hffff_0000; in_mark = 32'h0000_8000; end
      default: begin in_keep = 32'hffff_ff00; in_mark = 32'h0000_0080; end
    endcase
  end

  assign in_word = in_full ? data_word : ((data_word & in_keep) | in_mark);

  // Bit length = byte count * 8, split into the two closing words.
  assign len_hi = msg_bytes[LenW-1:LenW-32];
  assign len_lo = {msg_bytes[LenW-33:0], 3'b000};

  // Padding: marker first if still owed, then zeros, length in slots 14/15.
  always_comb begin
    if (pad_mark) begin
      pad_word = PadMarker;
    end else if (wib == 4'd14) begin
      pad_word = len_hi;
    end else if (wib == 4'd15 && len_phase) begin
      pad_word = len_lo;
    end else begin
      pad_word = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt == 7'd7) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (wib == 4'd15) begin
            state_next = ST_LOAD;
          end else if (in_ending) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (wib == 4'd15) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (cnt == 7'd16) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt == 7'd63) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (cnt == 7'd8) begin
          if (len_phase) begin
            state_next = ST_OUT_RD;
          end else if (pad_active) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT_RD:  state_next = ST_OUT_CAP;
      ST_OUT_CAP: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_xfer) state_next = msg_done ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Memory ports and datapath control.
  always_comb begin
    data_ready = 1'b0;
    blk_we     = 1'b0;
    blk_wdata  = pad_word;
    hsh_we     = 1'b0;
    hsh_waddr  = cnt[2:0];
    hsh_wdata  = iv_word(cnt[2:0]);
    hsh_raddr  = cnt[2:0];
    ctl        = '0;
    ctl.round  = cnt[5:0];
    case (state)
      ST_INIT: begin
        hsh_we = 1'b1;
      end
      ST_IDLE: begin
        data_ready = 1'b1;
        blk_we     = in_xfer;
        blk_wdata  = in_word;
      end
      ST_PAD: begin
        blk_we = 1'b1;
      end
      ST_LOAD: begin
        ctl.sched_load = (cnt != 7'd0);
        ctl.vars_load  = (cnt != 7'd0) && (cnt <= 7'd8);
      end
      ST_ROUND: begin
        ctl.sched_step = 1'b1;
        ctl.vars_round = 1'b1;
      end
      ST_FOLD: begin
        // read H[n] while writing back H[n-1] + working variable n-1
        ctl.vars_shift = (cnt != 7'd0);
        hsh_we         = (cnt != 7'd0);
        hsh_waddr      = cnt[2:0] - 3'd1;
        hsh_wdata      = hsh_rdata + var_a;
      end
      ST_OUT_RD: begin
        hsh_raddr = oidx;
      end
      ST_OUT_CAP: begin
        // digest word is captured now; reload the initial value behind it
        hsh_raddr = oidx;
        hsh_we    = 1'b1;
        hsh_waddr = oidx;
        hsh_wdata = iv_word(oidx);
      end
      ST_OUT_WAIT: begin
        hsh_raddr = oidx;
      end
      default: begin
        data_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      cnt          <= '0;
      wib          <= '0;
      msg_bytes    <= '0;
      pad_active   <= 1'b0;
      pad_mark     <= 1'b0;
      len_phase    <= 1'b0;
      oidx         <= '0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 7'd0 : cnt + 7'd1;

      if (blk_we) begin
        wib <= wib + 4'd1;
      end

      if (in_xfer) begin
        msg_bytes  <= msg_bytes + {{(LenW-3){1'b0}}, in_count};
        pad_active <= in_ending;
        pad_mark   <= in_full && in_ending;
      end else if (msg_done) begin
        msg_bytes  <= '0;
        pad_active <= 1'b0;
      end

      if (state == ST_PAD) begin
        pad_mark <= 1'b0;
        if (!pad_mark && wib == 4'd14) begin
          len_phase <= 1'b1;
        end
      end else if (msg_done) begin
        len_phase <= 1'b0;
      end

      if (out_xfer) begin
        oidx <= oidx + 3'd1;
      end

      if (state == ST_OUT_CAP) begin
        digest_valid <= 1'b1;
      end else if (out_xfer) begin
        digest_valid <= 1'b0;
      end
    end
  end

  // Hold the digest word until its transfer.
  always_ff @(posedge clk) begin
    if (state == ST_OUT_CAP) begin
      digest_word <= hsh_rdata;
    end
  end

  assign word_index = oidx;
  assign digest_end = (oidx == 3'd7);

  s256_ram #(
    .Width (WordW),
    .Depth (BlockDepth)
  ) u_block_mem (
    .clk   (clk),
    .we    (blk_we),
    .waddr (wib),
    .wdata (blk_wdata),
    .raddr (cnt[3:0]),
    .rdata (blk_rdata)
  );

  s256_ram #(
    .Width (WordW),
    .Depth (HashDepth)
  ) u_hash_mem (
    .clk   (clk),
    .we    (hsh_we),
    .waddr (hsh_waddr),
    .wdata (hsh_wdata),
    .raddr (hsh_raddr),
    .rdata (hsh_rdata)
  );

  s256_sched u_sched (
    .clk       (clk),
    .ctl       (ctl),
    .load_word (blk_rdata),
    .w_cur     (w_cur)
  );

  s256_round u_round (
    .clk       (clk),
    .ctl       (ctl),
    .load_word (hsh_rdata),
    .w_cur     (w_cur),
    .var_a     (var_a)
  );

  // No new message word while a digest word is waiting.
  a_no_input_during_output: assert property (
    @(posedge clk) disable iff (rst) digest_valid |-> !data_ready
  ) else $error("input taken while digest word pending");

  // The sixteenth word of a block must start a compression.
  a_full_block_compresses: assert property (
    @(posedge clk) disable iff (rst)
    (data_valid && data_ready && wib == 4'd15) |=> (state == ST_LOAD)
  ) else $error("full block did not start compression");

  // After the final digest word, the message context is clean.
  a_clean_after_digest: assert property (
    @(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && digest_end) |=>
      (msg_bytes == '0 && !pad_active && !len_phase && wib == 4'd0)
  ) else $error("message context not cleared after digest");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SHA-256 stream hasher. Message words go in
// through a bursty sender; each accepted word runs through a software hash
// model kept in the bench, and every digest word that comes out is compared
// with the oldest word that the model expects.
// ----------------------------------------------------------------------------
module tb import s256_pkg::*; ();

  // FIPS 180-4 initial hash values and round constants
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam int          LEN_SLOT   = 14;   // first of the two length words
  localparam int          DRAIN_WAIT = 150;  // a compression plus output time

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [2:0]       idx;
    logic             tail;
  } digest_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             data_valid = 1'b0;
  logic             data_ready;
  logic [WordW-1:0] data_word = '0;
  logic [2:0]       byte_count = '0;
  logic             last_word = 1'b0;
  logic             digest_valid;
  logic             digest_ready = 1'b0;
  logic [WordW-1:0] digest_word;
  logic [2:0]       word_index;
  logic             digest_end;

  // hash model state
  logic [31:0] chain_hash [8];
  logic [31:0] msg_block [16];
  int unsigned block_fill;
  logic [60:0] msg_byte_len;
  digest_t     pending_digest [$];

  // sender pacing and run statistics
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned digest_words_seen = 0;
  int unsigned messages_hashed = 0;
  int unsigned fail_count = 0;

  sha256_stream_hasher_core dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .digest_end   (digest_end)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Hash model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  // Run the 64 rounds over msg_block and fold the result into chain_hash.
  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) sched[i] = msg_block[i];
    for (i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    for (i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
  endfunction

  function automatic void block_push(input logic [31:0] w);
    msg_block[block_fill] = w;
    block_fill++;
    if (block_fill == 16) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic void restart_message();
    int i;
    for (i = 0; i < 8; i++) chain_hash[i] = HASH_IV[i];
    block_fill   = 0;
    msg_byte_len = '0;
  endfunction

  // Advance the model by one accepted word; queue the digest when it closes.
  function automatic void hash_word(input logic [31:0] d, input logic [2:0] cnt,
                                    input logic lst);
    int unsigned nbytes;
    logic        closing;
    logic [31:0] keep;
    logic [63:0] bit_len;
    digest_t     dw;
    int          i;
    nbytes  = (cnt > 3'd4) ? 4 : cnt;   // oversized counts read as a full word
    closing = lst || (nbytes < 4);      // a short word always closes
    msg_byte_len = msg_byte_len + 61'(nbytes);
    if (nbytes == 4) begin
      block_push(d);
      if (!closing) return;
      block_push(PAD_WORD);
    end else begin
      // drop the invalid trailing bytes and place the pad marker after the data
      keep = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nbytes));
      block_push((d & keep) | (32'h80 << (24 - 8 * nbytes)));
    end
    // no room for the length: pad out this block and start another
    if (block_fill > LEN_SLOT) begin
      while (block_fill != 0) block_push(32'h0);
    end
    while (block_fill < LEN_SLOT) block_push(32'h0);
    bit_len = {msg_byte_len, 3'b000};
    block_push(bit_len[63:32]);
    block_push(bit_len[31:0]);
    for (i = 0; i < 8; i++) begin
      dw.word = chain_hash[i];
      dw.idx  = 3'(i);
      dw.tail = (i == 7);
      pending_digest.push_back(dw);
    end
    restart_message();
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one message word per call, in bursts with idle gaps in between.
  // Each call starts and returns right after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] d, input logic [2:0] cnt, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    // hold valid high and the payload steady until the transfer
    data_valid <= 1'b1;
    data_word  <= d;
    byte_count <= cnt;
    last_word  <= lst;
    do @(posedge clk); while (!data_ready);
    words_sent++;
    hash_word(d, cnt, lst);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall in one of four modes, redrawn at random: always ready,
  // mostly ready, mostly stalled, and ready one cycle in four.
  // --------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_cyc = 0;

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 48 == 47) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: digest_ready <= 1'b1;
      1: digest_ready <= ($urandom_range(0, 3) != 0);
      2: digest_ready <= ($urandom_range(0, 3) == 0);
      default: digest_ready <= (stall_cyc % 4 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Digest checker: compare every digest transfer with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_t want;
    if (!rst && digest_valid && digest_ready) begin
      digest_words_seen++;
      if (digest_end) messages_hashed++;
      if (pending_digest.size() == 0) begin
        $error("digest transfer with nothing expected: digest_word %h word_index %0d",
               digest_word, word_index);
        fail_count++;
      end else begin
        want = pending_digest.pop_front();
        if (digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, digest_word);
          fail_count++;
        end
        if (word_index !== want.idx) begin
          $error("word_index: expected %0d, got %0d", want.idx, word_index);
          fail_count++;
        end
        if (digest_end !== want.tail) begin
          $error("digest_end: expected %0b, got %0b", want.tail, digest_end);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty message, then a zero-byte word without last that still closes one.
  task automatic test_empty_message();
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd0, 1'b0);
  endtask

  // Short closing words with junk in the unused bytes, last set and clear.
  task automatic test_short_words();
    send_word(32'h6162_63a5, 3'd3, 1'b0);   // "abc"
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b0);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'h1234_5678, 3'd3, 1'b1);
  endtask

  // Counts of 5..7 act as full words; close on a full last word.
  task automatic test_oversized_counts();
    send_word(32'hdead_beef, 3'd5, 1'b0);
    send_word(32'h0000_0000, 3'd6, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
  endtask

  // Fourteen full words: the pad marker leaves no room for the length, so
  // the padding spills into a second block.
  task automatic test_two_block_padding();
    int k;
    for (k = 0; k < 14; k++) begin
      case (k % 3)
        0: send_word(32'hffff_ffff, 3'd4, k == 13);
        1: send_word(32'h0000_0000, 3'd4, k == 13);
        default: send_word($urandom, 3'd4, k == 13);
      endcase
    end
  endtask

  // Random messages: mostly short, some near and across block boundaries,
  // a few several blocks long; every closing form appears.
  task automatic test_random_messages(input int unsigned word_budget);
    int unsigned used;
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    logic [2:0]  cnt;
    used = 0;
    while (used < word_budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 16);
      else if (pick < 9) len = $urandom_range(12, 34);
      else len = $urandom_range(40, 70);
      for (k = 0; k < len; k++) begin
        cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
        send_word($urandom, cnt, 1'b0);
      end
      case ($urandom_range(0, 3))
        0, 1: send_word($urandom, 3'd4, 1'b1);
        2: send_word($urandom, 3'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        default: send_word($urandom, 3'($urandom_range(5, 7)), 1'b1);
      endcase
      used += len + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    restart_message();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_short_words();
    test_oversized_counts();
    test_two_block_padding();
    test_random_messages(260);

    // drop valid and drain the outstanding digests
    data_valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d message words; checked %0d digest words over %0d messages.",
             words_sent, digest_words_seen, messages_hashed);
    $display("Covered empty, short, oversized-count and two-block-padding endings.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Timeout with %0d digest words still expected", pending_digest.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
